// ===== rtl/abr_pkg.sv =====
`default_nettype none

package abr_pkg;

  localparam int SRC_DIM_W  = 7;
  localparam int DST_DIM_W  = 9;
  localparam int COORD_W    = 8;
  localparam int PIXEL_W    = 32;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int DEF_MAX_SRC_WIDTH  = 64;
  localparam int DEF_MAX_SRC_HEIGHT = 64;
  localparam int DEF_MAX_DST_DIM    = 256;
  localparam int DEF_FRAC_BITS      = 16;

  localparam logic [SRC_DIM_W-1:0] RESET_SRC_DIM = SRC_DIM_W'(32);
  localparam logic [DST_DIM_W-1:0] RESET_DST_DIM = DST_DIM_W'(32);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_DST_WIDTH  = 2'd2,
    CFG_DST_HEIGHT = 2'd3
  } cfg_index_t;

endpackage

`default_nettype wire

// ===== rtl/abr_ram.sv =====
`default_nettype none

module abr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                       wdata,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/abr_ratio.sv =====
`default_nettype none

// Restoring divider that produces one quotient bit per cycle.
module abr_ratio #(
  parameter int Q_W   = 23,
  parameter int DEN_W = 9
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [Q_W-1:0]   num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic      [Q_W-1:0]   quo
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [Q_W-1:0]   nq;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_next;
  logic [Q_W-1:0]   nq_next;

  always_comb begin
    trial    = {rem, nq[Q_W-1]};
    ge       = trial >= {1'b0, den};
    rem_next = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    nq_next  = Q_W'({nq, ge});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(Q_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      nq  <= num;
    end else if (cnt != '0) begin
      rem <= rem_next;
      nq  <= nq_next;
    end
  end

  assign busy = cnt != '0;
  assign quo  = nq;

endmodule

`default_nettype wire

// ===== rtl/abr_div.sv =====
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. The numerator must satisfy (num >> Q_W) < den.
module abr_div #(
  parameter int LANES = 3,
  parameter int NUM_W = 24,
  parameter int DEN_W = 17,
  parameter int Q_W   = 8,
  parameter int TAG_W = 9
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [LANES-1:0][NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0]            den,
  input  wire logic [TAG_W-1:0]            tag,
  output logic                             out_valid,
  output logic      [LANES-1:0][Q_W-1:0]   quo,
  output logic      [TAG_W-1:0]            out_tag
);

  logic [LANES-1:0][DEN_W-1:0] r_rem [Q_W];
  logic [LANES-1:0][Q_W-1:0]   r_nq  [Q_W];
  logic [DEN_W-1:0]            r_den [Q_W];
  logic [TAG_W-1:0]            r_tag [Q_W];
  logic [Q_W-1:0]              r_valid;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [LANES-1:0][DEN_W-1:0] p_rem;
    logic [LANES-1:0][Q_W-1:0]   p_nq;
    logic [DEN_W-1:0]            p_den;
    logic [TAG_W-1:0]            p_tag;
    logic                        p_valid;
    logic [LANES-1:0][DEN_W-1:0] rem_next;
    logic [LANES-1:0][Q_W-1:0]   nq_next;

    if (i == 0) begin : g_first
      for (genvar l = 0; l < LANES; l++) begin : g_init
        assign p_rem[l] = DEN_W'(num[l] >> Q_W);
        assign p_nq[l]  = num[l][Q_W-1:0];
      end
      assign p_den   = den;
      assign p_tag   = tag;
      assign p_valid = in_valid;
    end else begin : g_next
      assign p_rem   = r_rem[i-1];
      assign p_nq    = r_nq[i-1];
      assign p_den   = r_den[i-1];
      assign p_tag   = r_tag[i-1];
      assign p_valid = r_valid[i-1];
    end

    always_comb begin
      logic [DEN_W:0] trial;
      logic           ge;
      for (int l = 0; l < LANES; l++) begin
        trial       = {p_rem[l], p_nq[l][Q_W-1]};
        ge          = trial >= {1'b0, p_den};
        rem_next[l] = ge ? DEN_W'(trial - {1'b0, p_den}) : trial[DEN_W-1:0];
        nq_next[l]  = Q_W'({p_nq[l], ge});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        r_valid[i] <= 1'b0;
      end else begin
        r_valid[i] <= p_valid;
      end
    end

    always_ff @(posedge clk) begin
      r_rem[i] <= rem_next;
      r_nq[i]  <= nq_next;
      r_den[i] <= p_den;
      r_tag[i] <= p_tag;
    end
  end

  assign out_valid = r_valid[Q_W-1];
  assign quo       = r_nq[Q_W-1];
  assign out_tag   = r_tag[Q_W-1];

endmodule

`default_nettype wire

// ===== rtl/alpha_aware_bilinear_resizer.sv =====
`default_nettype none

// Alpha-aware bilinear RGBA8 resizer.
// Requests enter on start while busy is low, with kind, col, row and
// pixel_word. A write (kind 0) stores pixel_word at source column col and
// row row and gives no result. A read (kind 1) returns the destination
// pixel at column col and row row on red_out..alpha_out, flagged by done
// for exactly one cycle. done comes from the last divider stage, after the
// capture, position, neighbour, bank and sum stages.
// One request is taken every cycle while busy is low; writes and reads
// are handled in order, so a read sees every write issued before it.
// The four size registers are written through wr_en, wr_index and wr_data.
// After reset and after every register write the per-axis step is
// recomputed by a bit-serial divider for each axis, and busy stays high
// until both have finished; these dividers set the only gap in the
// request stream.
// The source store is split into four banks by column and row parity, so
// all four neighbours are read in the same cycle. Its contents are undefined
// until written. The receiver cannot stall: results are never held back.
module alpha_aware_bilinear_resizer #(
  parameter int MAX_SRC_WIDTH  = abr_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = abr_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int MAX_DST_DIM    = abr_pkg::DEF_MAX_DST_DIM,
  parameter int FRAC_BITS      = abr_pkg::DEF_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              kind,
  input  wire logic [abr_pkg::COORD_W-1:0]       col,
  input  wire logic [abr_pkg::COORD_W-1:0]       row,
  input  wire logic [abr_pkg::PIXEL_W-1:0]       pixel_word,
  input  wire logic                              wr_en,
  input  wire logic [abr_pkg::CFG_IDX_W-1:0]     wr_index,
  input  wire logic [abr_pkg::CFG_DATA_W-1:0]    wr_data,
  output logic                                   done,
  output logic      [abr_pkg::CH_W-1:0]          red_out,
  output logic      [abr_pkg::CH_W-1:0]          green_out,
  output logic      [abr_pkg::CH_W-1:0]          blue_out,
  output logic      [abr_pkg::CH_W-1:0]          alpha_out
);

  localparam int SW      = abr_pkg::SRC_DIM_W;
  localparam int DW      = abr_pkg::DST_DIM_W;
  localparam int CW      = abr_pkg::COORD_W;
  localparam int PW      = abr_pkg::PIXEL_W;
  localparam int CH      = abr_pkg::CH_W;
  localparam int RATIO_W = SW + FRAC_BITS;
  localparam int POS_W   = RATIO_W + CW;
  localparam int IP_W    = POS_W - FRAC_BITS;
  localparam int ONE_W   = FRAC_BITS + 1;
  localparam int PROD_W  = 2 * ONE_W;
  localparam int ACC_W   = FRAC_BITS + CH;
  localparam int HALF_W  = (MAX_SRC_WIDTH + 1) / 2;
  localparam int HALF_H  = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int BANK_AW = BANK_DEPTH > 1 ? $clog2(BANK_DEPTH) : 1;
  localparam int TAG_W   = CH + 1;
  localparam logic [ONE_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  // Configuration registers.
  logic [SW-1:0] src_width, src_height;
  logic [DW-1:0] dst_width, dst_height;
  logic          recalc;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= abr_pkg::RESET_SRC_DIM;
      src_height <= abr_pkg::RESET_SRC_DIM;
      dst_width  <= abr_pkg::RESET_DST_DIM;
      dst_height <= abr_pkg::RESET_DST_DIM;
      recalc     <= 1'b1;
    end else begin
      recalc <= wr_en;
      if (wr_en) begin
        unique case (abr_pkg::cfg_index_t'(wr_index))
          abr_pkg::CFG_SRC_WIDTH:  src_width  <= wr_data[SW-1:0];
          abr_pkg::CFG_SRC_HEIGHT: src_height <= wr_data[SW-1:0];
          abr_pkg::CFG_DST_WIDTH:  dst_width  <= wr_data[DW-1:0];
          abr_pkg::CFG_DST_HEIGHT: dst_height <= wr_data[DW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Effective sizes: zero means one; sizes above the store or MAX_DST_DIM are capped.
  logic [SW-1:0] sw_eff, sh_eff, xm1, ym1;
  logic [DW-1:0] dw_eff, dh_eff;

  always_comb begin
    if (src_width == '0) sw_eff = SW'(1);
    else if (32'(src_width) > MAX_SRC_WIDTH) sw_eff = SW'(MAX_SRC_WIDTH);
    else sw_eff = src_width;
    if (src_height == '0) sh_eff = SW'(1);
    else if (32'(src_height) > MAX_SRC_HEIGHT) sh_eff = SW'(MAX_SRC_HEIGHT);
    else sh_eff = src_height;
    if (dst_width == '0) dw_eff = DW'(1);
    else if (32'(dst_width) > MAX_DST_DIM) dw_eff = DW'(MAX_DST_DIM);
    else dw_eff = dst_width;
    if (dst_height == '0) dh_eff = DW'(1);
    else if (32'(dst_height) > MAX_DST_DIM) dh_eff = DW'(MAX_DST_DIM);
    else dh_eff = dst_height;
    xm1 = sw_eff - 1'b1;
    ym1 = sh_eff - 1'b1;
  end

  logic [RATIO_W-1:0] ratio_x, ratio_y;
  logic               rx_busy, ry_busy;

  abr_ratio #(.Q_W(RATIO_W), .DEN_W(DW)) u_ratio_x (
    .clk(clk), .rst(rst), .start(recalc),
    .num(RATIO_W'(xm1) << FRAC_BITS), .den(dw_eff),
    .busy(rx_busy), .quo(ratio_x)
  );

  abr_ratio #(.Q_W(RATIO_W), .DEN_W(DW)) u_ratio_y (
    .clk(clk), .rst(rst), .start(recalc),
    .num(RATIO_W'(ym1) << FRAC_BITS), .den(dh_eff),
    .busy(ry_busy), .quo(ratio_y)
  );

  assign busy = recalc | rx_busy | ry_busy;

  // Stage 1: request capture.
  logic          v1, k1;
  logic [CW-1:0] col1, row1;
  logic [PW-1:0] pix1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start & ~busy;
  end

  always_ff @(posedge clk) begin
    k1   <= kind;
    col1 <= col;
    row1 <= row;
    pix1 <= pixel_word;
  end

  // Stage 2: source position on each axis.
  logic             v2, k2;
  logic [CW-1:0]    col2, row2;
  logic [PW-1:0]    pix2;
  logic [POS_W-1:0] posx2, posy2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
  end

  always_ff @(posedge clk) begin
    k2    <= k1;
    col2  <= col1;
    row2  <= row1;
    pix2  <= pix1;
    posx2 <= POS_W'(ratio_x) * POS_W'(col1);
    posy2 <= POS_W'(ratio_y) * POS_W'(row1);
  end

  // Stage 3: neighbour coordinates and fractions.
  logic [SW-1:0] x0_c, x1_c, y0_c, y1_c;

  always_comb begin
    if (posx2[POS_W-1:FRAC_BITS] > IP_W'(xm1)) x0_c = xm1;
    else x0_c = SW'(posx2[POS_W-1:FRAC_BITS]);
    if (posy2[POS_W-1:FRAC_BITS] > IP_W'(ym1)) y0_c = ym1;
    else y0_c = SW'(posy2[POS_W-1:FRAC_BITS]);
    x1_c = (x0_c < xm1) ? x0_c + 1'b1 : xm1;
    y1_c = (y0_c < ym1) ? y0_c + 1'b1 : ym1;
  end

  logic                 v3, k3;
  logic [CW-1:0]        col3, row3;
  logic [PW-1:0]        pix3;
  logic [SW-1:0]        x0_3, x1_3, y0_3, y1_3;
  logic [FRAC_BITS-1:0] fx3, fy3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
  end

  always_ff @(posedge clk) begin
    k3   <= k2;
    col3 <= col2;
    row3 <= row2;
    pix3 <= pix2;
    x0_3 <= x0_c;
    x1_3 <= x1_c;
    y0_3 <= y0_c;
    y1_3 <= y1_c;
    fx3  <= posx2[FRAC_BITS-1:0];
    fy3  <= posy2[FRAC_BITS-1:0];
  end

  // Bank b holds the pixels whose row parity is b[1] and column parity b[0].
  logic               is_write3, wr_ok3;
  logic [BANK_AW-1:0] waddr3;
  logic [BANK_AW-1:0] bank_addr [4];
  logic [3:0]         bank_we;
  logic [PW-1:0]      bank_rd [4];

  always_comb begin
    is_write3 = v3 && (k3 == abr_pkg::KIND_WRITE);
    wr_ok3    = is_write3 && (32'(col3) < MAX_SRC_WIDTH) && (32'(row3) < MAX_SRC_HEIGHT);
    waddr3    = BANK_AW'(32'(row3 >> 1) * HALF_W + 32'(col3 >> 1));
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [SW-1:0] xs, ys;

    always_comb begin
      xs = (x0_3[0] == 1'(b % 2)) ? x0_3 : x1_3;
      ys = (y0_3[0] == 1'(b / 2)) ? y0_3 : y1_3;
      bank_we[b]   = wr_ok3 && ({row3[0], col3[0]} == 2'(b));
      bank_addr[b] = is_write3 ? waddr3
                               : BANK_AW'(32'(ys >> 1) * HALF_W + 32'(xs >> 1));
    end

    abr_ram #(.WIDTH(PW), .DEPTH(BANK_DEPTH)) u_ram (
      .clk(clk), .we(bank_we[b]), .addr(bank_addr[b]),
      .wdata(pix3), .rdata(bank_rd[b])
    );
  end

  logic [ONE_W-1:0]  ofx, ofy;
  logic [PROD_W-1:0] wp [4];

  always_comb begin
    ofx   = ONE_Q - {1'b0, fx3};
    ofy   = ONE_Q - {1'b0, fy3};
    wp[0] = PROD_W'(ofx) * PROD_W'(ofy);
    wp[1] = PROD_W'({1'b0, fx3}) * PROD_W'(ofy);
    wp[2] = PROD_W'(ofx) * PROD_W'({1'b0, fy3});
    wp[3] = PROD_W'({1'b0, fx3}) * PROD_W'({1'b0, fy3});
  end

  // Stage 4: bank data and weights.
  logic             v4;
  logic             x0p, x1p, y0p, y1p;
  logic [ONE_W-1:0] w4 [4];

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3 && (k3 == abr_pkg::KIND_READ);
  end

  always_ff @(posedge clk) begin
    x0p <= x0_3[0];
    x1p <= x1_3[0];
    y0p <= y0_3[0];
    y1p <= y1_3[0];
    for (int k = 0; k < 4; k++) begin
      w4[k] <= ONE_W'(wp[k] >> FRAC_BITS);
    end
  end

  logic [PW-1:0]    nb [4];
  logic [ACC_W-1:0] acc_c [3];
  logic [ACC_W-1:0] acc_a, tot_c;

  always_comb begin
    nb[0] = bank_rd[{y0p, x0p}];
    nb[1] = bank_rd[{y0p, x1p}];
    nb[2] = bank_rd[{y1p, x0p}];
    nb[3] = bank_rd[{y1p, x1p}];
    acc_a = '0;
    tot_c = '0;
    for (int c = 0; c < 3; c++) begin
      acc_c[c] = '0;
    end
    for (int k = 0; k < 4; k++) begin
      acc_a = acc_a + ACC_W'(nb[k][31:24]) * ACC_W'(w4[k]);
      // Fully transparent neighbours do not contribute to the color.
      if (nb[k][31:24] != '0) begin
        tot_c = tot_c + ACC_W'(w4[k]);
        for (int c = 0; c < 3; c++) begin
          acc_c[c] = acc_c[c] + ACC_W'(nb[k][c*CH +: CH]) * ACC_W'(w4[k]);
        end
      end
    end
  end

  // Stage 5: weighted sums.
  logic                        v5;
  logic [2:0][ACC_W-1:0]       acc5;
  logic [ONE_W-1:0]            tot5;
  logic [CH-1:0]               alpha5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else v5 <= v4;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      acc5[c] <= acc_c[c];
    end
    tot5   <= ONE_W'(tot_c);
    alpha5 <= acc_a[ACC_W-1:FRAC_BITS];
  end

  logic                 dv;
  logic [2:0][CH-1:0]   quo;
  logic [TAG_W-1:0]     dtag;

  abr_div #(.LANES(3), .NUM_W(ACC_W), .DEN_W(ONE_W), .Q_W(CH), .TAG_W(TAG_W)) u_div (
    .clk(clk), .rst(rst), .in_valid(v5),
    .num(acc5), .den(tot5), .tag({alpha5, tot5 == '0}),
    .out_valid(dv), .quo(quo), .out_tag(dtag)
  );

  assign done      = dv;
  assign red_out   = dtag[0] ? '0 : quo[0];
  assign green_out = dtag[0] ? '0 : quo[1];
  assign blue_out  = dtag[0] ? '0 : quo[2];
  assign alpha_out = dtag[TAG_W-1:1];

endmodule

`default_nettype wire

// ===== dv/alpha_aware_bilinear_resizer_tb.sv =====
`default_nettype none

module alpha_aware_bilinear_resizer_tb;

  localparam int STORE_COLS = abr_pkg::DEF_MAX_SRC_WIDTH;
  localparam int STORE_ROWS = abr_pkg::DEF_MAX_SRC_HEIGHT;
  localparam int MAX_DST = abr_pkg::DEF_MAX_DST_DIM;
  localparam int Q = abr_pkg::DEF_FRAC_BITS;
  localparam logic [63:0] ONE = 64'd1 << Q;

  typedef struct packed {
    logic                          kind;
    logic [abr_pkg::COORD_W-1:0]   col;
    logic [abr_pkg::COORD_W-1:0]   row;
    logic [abr_pkg::PIXEL_W-1:0]   pix;
  } request_t;

  typedef struct packed {
    logic [abr_pkg::CH_W-1:0] r;
    logic [abr_pkg::CH_W-1:0] g;
    logic [abr_pkg::CH_W-1:0] b;
    logic [abr_pkg::CH_W-1:0] a;
  } rgba_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic kind = abr_pkg::KIND_WRITE;
  logic [abr_pkg::COORD_W-1:0] col = '0;
  logic [abr_pkg::COORD_W-1:0] row = '0;
  logic [abr_pkg::PIXEL_W-1:0] pixel_word = '0;
  logic wr_en = 1'b0;
  logic [abr_pkg::CFG_IDX_W-1:0] wr_index = abr_pkg::CFG_SRC_WIDTH;
  logic [abr_pkg::CFG_DATA_W-1:0] wr_data = '0;
  logic busy, done;
  logic [abr_pkg::CH_W-1:0] red_out, green_out, blue_out, alpha_out;

  alpha_aware_bilinear_resizer i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .col(col),
    .row(row), .pixel_word(pixel_word), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data), .done(done), .red_out(red_out), .green_out(green_out),
    .blue_out(blue_out), .alpha_out(alpha_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [abr_pkg::PIXEL_W-1:0] src_image [STORE_COLS*STORE_ROWS];
  // Entries that some queued write has already covered.
  bit written [STORE_COLS*STORE_ROWS];
  logic [abr_pkg::SRC_DIM_W-1:0] src_w_reg = abr_pkg::RESET_SRC_DIM;
  logic [abr_pkg::SRC_DIM_W-1:0] src_h_reg = abr_pkg::RESET_SRC_DIM;
  logic [abr_pkg::DST_DIM_W-1:0] dst_w_reg = abr_pkg::RESET_DST_DIM;
  logic [abr_pkg::DST_DIM_W-1:0] dst_h_reg = abr_pkg::RESET_DST_DIM;

  request_t pending [$];
  rgba_t expected_pixels [$];
  request_t on_bus;
  int idle_pct = 0;
  logic hold = 1'b0;
  bit failed = 0;

  function automatic logic [63:0] fit_dim(logic [63:0] v, logic [63:0] maxv);
    if (v == 0) return 64'd1;
    return (v > maxv) ? maxv : v;
  endfunction

  // Integer neighbours and fraction along one axis.
  function automatic void map_axis(input logic [63:0] src, input logic [63:0] dst,
                                   input logic [63:0] idx, output logic [63:0] i0,
                                   output logic [63:0] i1, output logic [63:0] fr);
    logic [63:0] step, pos;
    step = ((src - 1) << Q) / dst;
    pos = step * idx;
    fr = pos & (ONE - 1);
    i0 = pos >> Q;
    if (i0 > src - 1) i0 = src - 1;
    i1 = (i0 + 1 < src) ? i0 + 1 : src - 1;
  endfunction

  function automatic rgba_t interpolate(logic [abr_pkg::COORD_W-1:0] dc,
                                        logic [abr_pkg::COORD_W-1:0] dr);
    logic [63:0] sw, sh, dw, dh, x0, x1, y0, y1, fx, fy, total, acc;
    logic [63:0] w [4];
    logic [31:0] p [4];
    logic [7:0] ch [3];
    rgba_t res;
    sw = fit_dim(64'(src_w_reg), 64'(STORE_COLS));
    sh = fit_dim(64'(src_h_reg), 64'(STORE_ROWS));
    dw = fit_dim(64'(dst_w_reg), 64'(MAX_DST));
    dh = fit_dim(64'(dst_h_reg), 64'(MAX_DST));
    map_axis(sw, dw, 64'(dc), x0, x1, fx);
    map_axis(sh, dh, 64'(dr), y0, y1, fy);
    p[0] = src_image[y0*STORE_COLS + x0];
    p[1] = src_image[y0*STORE_COLS + x1];
    p[2] = src_image[y1*STORE_COLS + x0];
    p[3] = src_image[y1*STORE_COLS + x1];
    w[0] = ((ONE - fx) * (ONE - fy)) >> Q;
    w[1] = (fx * (ONE - fy)) >> Q;
    w[2] = ((ONE - fx) * fy) >> Q;
    w[3] = (fx * fy) >> Q;
    total = 0;
    for (int k = 0; k < 4; k++) if (p[k][31:24] != 0) total += w[k];
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      for (int k = 0; k < 4; k++)
        if (p[k][31:24] != 0) acc += 64'(p[k][8*c +: 8]) * w[k];
      ch[c] = (total != 0) ? 8'(acc / total) : 8'd0;
    end
    acc = 0;
    for (int k = 0; k < 4; k++) acc += 64'(p[k][31:24]) * w[k];
    res.r = ch[0];
    res.g = ch[1];
    res.b = ch[2];
    res.a = 8'(acc >> Q);
    return res;
  endfunction

  function automatic void accept_request(request_t rq);
    if (rq.kind == abr_pkg::KIND_WRITE) begin
      if (rq.col < STORE_COLS && rq.row < STORE_ROWS)
        src_image[rq.row*STORE_COLS + rq.col] = rq.pix;
    end else begin
      expected_pixels.insert(expected_pixels.size(), interpolate(rq.col, rq.row));
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) accept_request(on_bus);
      if (!start || !busy) begin
        if (pending.size() > 0 && !hold && $urandom_range(99) >= idle_pct) begin
          on_bus = pending.pop_front();
          start <= 1'b1;
          kind <= on_bus.kind;
          col <= on_bus.col;
          row <= on_bus.row;
          pixel_word <= on_bus.pix;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rgba_t want;
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result pixel");
        failed = 1;
      end else begin
        want = expected_pixels.pop_front();
        if (red_out !== want.r) begin
          $error("red_out expected %0d got %0d", want.r, red_out); failed = 1;
        end
        if (green_out !== want.g) begin
          $error("green_out expected %0d got %0d", want.g, green_out); failed = 1;
        end
        if (blue_out !== want.b) begin
          $error("blue_out expected %0d got %0d", want.b, blue_out); failed = 1;
        end
        if (alpha_out !== want.a) begin
          $error("alpha_out expected %0d got %0d", want.a, alpha_out); failed = 1;
        end
      end
    end
  end

  function automatic logic [31:0] random_pixel();
    logic [31:0] p;
    p = $urandom;
    if ($urandom_range(3) == 0) p[31:24] = 8'h00;
    return p;
  endfunction

  function automatic void queue_request(logic k, int c, int r, logic [31:0] p);
    request_t rq;
    rq.kind = k;
    rq.col = abr_pkg::COORD_W'(c);
    rq.row = abr_pkg::COORD_W'(r);
    rq.pix = p;
    if (k == abr_pkg::KIND_WRITE && c < STORE_COLS && r < STORE_ROWS)
      written[r*STORE_COLS + c] = 1'b1;
    pending.insert(pending.size(), rq);
  endfunction

  function automatic void fill_entry(int x, int y);
    if (!written[y*STORE_COLS + x]) queue_request(abr_pkg::KIND_WRITE, x, y, random_pixel());
  endfunction

  // A read is preceded by writes of any of its neighbours not yet written.
  function automatic void queue_read(int c, int r);
    logic [63:0] sw, sh, dw, dh, x0, x1, y0, y1, fx, fy;
    sw = fit_dim(64'(src_w_reg), 64'(STORE_COLS));
    sh = fit_dim(64'(src_h_reg), 64'(STORE_ROWS));
    dw = fit_dim(64'(dst_w_reg), 64'(MAX_DST));
    dh = fit_dim(64'(dst_h_reg), 64'(MAX_DST));
    map_axis(sw, dw, 64'(c), x0, x1, fx);
    map_axis(sh, dh, 64'(r), y0, y1, fy);
    fill_entry(int'(x0), int'(y0));
    fill_entry(int'(x1), int'(y0));
    fill_entry(int'(x0), int'(y1));
    fill_entry(int'(x1), int'(y1));
    queue_request(abr_pkg::KIND_READ, c, r, $urandom);
  endfunction

  // Mostly reads inside the destination, some outside, plus rewrites of the image.
  function automatic void queue_random(int n);
    int dw, dh;
    dw = int'(fit_dim(64'(dst_w_reg), 64'(MAX_DST)));
    dh = int'(fit_dim(64'(dst_h_reg), 64'(MAX_DST)));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1: queue_request(abr_pkg::KIND_WRITE, $urandom_range(63), $urandom_range(63),
                            random_pixel());
        2: queue_request(abr_pkg::KIND_WRITE, $urandom_range(255), $urandom_range(255),
                         $urandom);
        3: queue_read($urandom_range(255), $urandom_range(255));
        default: queue_read($urandom_range(dw-1), $urandom_range(dh-1));
      endcase
    end
  endfunction

  task automatic drain();
    while (pending.size() > 0 || start) @(posedge clk);
    while (expected_pixels.size() > 0) @(posedge clk);
    // Writes give no result and may still be in the pipeline.
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(abr_pkg::cfg_index_t idx, logic [abr_pkg::CFG_DATA_W-1:0] v);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= v;
    case (idx)
      abr_pkg::CFG_SRC_WIDTH:  src_w_reg = v[abr_pkg::SRC_DIM_W-1:0];
      abr_pkg::CFG_SRC_HEIGHT: src_h_reg = v[abr_pkg::SRC_DIM_W-1:0];
      abr_pkg::CFG_DST_WIDTH:  dst_w_reg = v;
      abr_pkg::CFG_DST_HEIGHT: dst_h_reg = v;
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic set_sizes(int sw, int sh, int dw, int dh);
    write_reg(abr_pkg::CFG_SRC_WIDTH, abr_pkg::CFG_DATA_W'(sw));
    write_reg(abr_pkg::CFG_SRC_HEIGHT, abr_pkg::CFG_DATA_W'(sh));
    write_reg(abr_pkg::CFG_DST_WIDTH, abr_pkg::CFG_DATA_W'(dw));
    write_reg(abr_pkg::CFG_DST_HEIGHT, abr_pkg::CFG_DATA_W'(dh));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 8;
    queue_request(abr_pkg::KIND_WRITE, 0, 0, 32'hff00_00ff);
    queue_request(abr_pkg::KIND_WRITE, 63, 63, 32'h0000_0000);
    queue_request(abr_pkg::KIND_WRITE, 64, 0, 32'hffff_ffff);
    queue_request(abr_pkg::KIND_WRITE, 0, 255, 32'hffff_ffff);
    queue_request(abr_pkg::KIND_WRITE, 1, 0, 32'h00ff_ffff);
    queue_request(abr_pkg::KIND_WRITE, 0, 1, 32'h0100_0000);
    queue_read(0, 0);
    queue_read(1, 1);
    queue_read(31, 31);
    queue_read(255, 255);
    queue_read(255, 0);
    queue_read(0, 255);
    queue_read(170, 85);
    queue_random(30);
    drain();

    set_sizes(64, 64, 256, 256);
    queue_read(255, 255);
    queue_random(25);
    drain();

    set_sizes(1, 1, 1, 1);
    queue_read(0, 0);
    queue_read(200, 17);
    // A single transparent neighbour leaves no valid color weight.
    queue_request(abr_pkg::KIND_WRITE, 0, 0, 32'h00ab_cdef);
    queue_read(0, 0);
    queue_random(20);
    drain();

    // Out-of-range sizes: zero and above the maximum.
    set_sizes(0, 127, 511, 0);
    queue_random(20);
    drain();

    idle_pct = 48;
    set_sizes(64, 1, 7, 200);
    queue_random(20);
    // The sender stops midway and waits until every expected result is back.
    while (pending.size() > 10) @(posedge clk);
    hold <= 1'b1;
    while (start || expected_pixels.size() > 0) @(posedge clk);
    hold <= 1'b0;
    queue_random(10);
    drain();

    idle_pct = 0;
    for (int ph = 0; ph < 4; ph++) begin
      set_sizes($urandom_range(1, 64), $urandom_range(1, 64),
                $urandom_range(1, 256), $urandom_range(1, 256));
      queue_random(15);
      drain();
    end

    if (!failed) $display("alpha_aware_bilinear_resizer_tb: done, clean");
    else $display("alpha_aware_bilinear_resizer_tb: done, errors");
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("alpha_aware_bilinear_resizer_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
